[rtl/mtd_pkg.sv]
// ----------------------------------------------------------------------------
// mtd_pkg
// shared types and constants of the markup text decoder
// ----------------------------------------------------------------------------
package mtd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_PERIOD   = 8'h2E;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_VTAB     = 8'h0B;
   localparam logic [7:0] CH_FORMFEED = 8'h0C;
   localparam logic [7:0] CH_RETURN   = 8'h0D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_TILDE    = 8'h7E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_B  = 8'h42;
   localparam logic [7:0] CH_UPPER_C  = 8'h43;
   localparam logic [7:0] CH_UPPER_H  = 8'h48;
   localparam logic [7:0] CH_UPPER_P  = 8'h50;
   localparam logic [7:0] CH_UPPER_R  = 8'h52;
   localparam logic [7:0] PRINT_LOW   = 8'h20;
   localparam logic [7:0] PRINT_END   = 8'h7F;

   typedef enum logic [5:0] {
      MODE_NORMAL = 6'b000001,
      MODE_CLOSE  = 6'b000010,
      MODE_OPEN   = 6'b000100,
      MODE_TOKEN  = 6'b001000,
      MODE_ARG    = 6'b010000,
      MODE_SKIP   = 6'b100000
   } mode_type;

   typedef enum logic [7:0] {
      TOK_NONE = 8'b00000001,
      TOK_R    = 8'b00000010,
      TOK_B    = 8'b00000100,
      TOK_P    = 8'b00001000,
      TOK_C    = 8'b00010000,
      TOK_CH   = 8'b00100000,
      TOK_CHA  = 8'b01000000,
      TOK_CHAR = 8'b10000000
   } token_type;

   typedef enum logic [6:0] {
      ARG_EMPTY  = 7'b0000001,
      ARG_TILDE1 = 7'b0000010,
      ARG_TILDE2 = 7'b0000100,
      ARG_WS     = 7'b0001000,
      ARG_SIGN   = 7'b0010000,
      ARG_DIGITS = 7'b0100000,
      ARG_DONE   = 7'b1000000
   } arg_type;

   // one queued transaction group: zero, one or two copies of a byte
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       twice;
      logic       eot;
   } entry_type;

   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] data;
   } emit_type;

endpackage

[rtl/mtd_front.sv]
// ----------------------------------------------------------------------------
// mtd_front
// markup parser: takes one byte per cycle while the queue is not full and queues the bytes it decodes
// ----------------------------------------------------------------------------
module mtd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                q_full,
   output logic                q_push,
   output mtd_pkg::entry_type  q_data
);

   mtd_pkg::mode_type  mode_ff, mode_in;
   mtd_pkg::token_type tok_ff, tok_in;
   mtd_pkg::arg_type   arg_ff, arg_in;
   logic [7:0]         arg_char_ff, arg_char_in;
   logic [7:0]         arg_value_ff, arg_value_in;
   logic               arg_neg_ff, arg_neg_in;

   logic               accept;
   logic [7:0]         c;
   logic               is_digit;
   logic               is_space;
   logic [3:0]         digit_val;
   logic [11:0]        acc;
   mtd_pkg::emit_type  emit;
   mtd_pkg::token_type tok_step;
   mtd_pkg::arg_type   step_mode;
   logic [7:0]         step_char;
   logic [7:0]         step_value;
   logic               step_neg;

   function automatic mtd_pkg::emit_type act_token(mtd_pkg::token_type t);
      mtd_pkg::emit_type e;
      e.data = 8'h00;
      e.cnt  = 2'd0;
      if (t == mtd_pkg::TOK_R || t == mtd_pkg::TOK_P) begin
         e.data = mtd_pkg::CH_NEWLINE;
         e.cnt  = 2'd1;
      end else if (t == mtd_pkg::TOK_B) begin
         e.data = mtd_pkg::CH_NEWLINE;
         e.cnt  = 2'd2;
      end
      return e;
   endfunction

   function automatic mtd_pkg::emit_type finish_arg(mtd_pkg::arg_type m, logic [7:0] ch,
                                                    logic [7:0] v, logic neg);
      mtd_pkg::emit_type e;
      e.data = 8'h00;
      e.cnt  = 2'd0;
      if (m == mtd_pkg::ARG_TILDE2) begin
         e.data = ch;
         e.cnt  = 2'd1;
      end else if ((m == mtd_pkg::ARG_DIGITS || m == mtd_pkg::ARG_DONE) && !neg &&
                   v >= mtd_pkg::PRINT_LOW && v < mtd_pkg::PRINT_END) begin
         e.data = v;
         e.cnt  = 2'd1;
      end
      return e;
   endfunction

   function automatic mtd_pkg::token_type tok_first(logic [7:0] ch);
      mtd_pkg::token_type t;
      case (ch)
         mtd_pkg::CH_UPPER_R: t = mtd_pkg::TOK_R;
         mtd_pkg::CH_UPPER_B: t = mtd_pkg::TOK_B;
         mtd_pkg::CH_UPPER_P: t = mtd_pkg::TOK_P;
         mtd_pkg::CH_UPPER_C: t = mtd_pkg::TOK_C;
         default:             t = mtd_pkg::TOK_NONE;
      endcase
      return t;
   endfunction

   function automatic mtd_pkg::token_type tok_follow(mtd_pkg::token_type t, logic [7:0] ch);
      mtd_pkg::token_type r;
      r = mtd_pkg::TOK_NONE;
      if (t == mtd_pkg::TOK_C && ch == mtd_pkg::CH_UPPER_H) begin
         r = mtd_pkg::TOK_CH;
      end else if (t == mtd_pkg::TOK_CH && ch == mtd_pkg::CH_UPPER_A) begin
         r = mtd_pkg::TOK_CHA;
      end else if (t == mtd_pkg::TOK_CHA && ch == mtd_pkg::CH_UPPER_R) begin
         r = mtd_pkg::TOK_CHAR;
      end
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign is_digit   = (c >= mtd_pkg::CH_ZERO) && (c <= mtd_pkg::CH_NINE);
   assign digit_val  = 4'(c - mtd_pkg::CH_ZERO);
   assign is_space   = (c == mtd_pkg::CH_SPACE) || (c == mtd_pkg::CH_TAB) ||
                       (c == mtd_pkg::CH_NEWLINE) || (c == mtd_pkg::CH_VTAB) ||
                       (c == mtd_pkg::CH_FORMFEED) || (c == mtd_pkg::CH_RETURN);
   assign acc        = {1'b0, arg_value_ff, 3'b000} + {3'b000, arg_value_ff, 1'b0} +
                       {8'h00, digit_val};
   assign tok_step   = tok_follow(tok_ff, c);

   // argument parser: whitespace, sign, decimal digits or a tilde character
   always_comb begin
      step_mode  = arg_ff;
      step_char  = arg_char_ff;
      step_value = arg_value_ff;
      step_neg   = arg_neg_ff;
      case (arg_ff)
         mtd_pkg::ARG_EMPTY, mtd_pkg::ARG_WS: begin
            if (is_space) begin
               step_mode = mtd_pkg::ARG_WS;
            end else if (c == mtd_pkg::CH_PLUS || c == mtd_pkg::CH_MINUS) begin
               step_neg  = (c == mtd_pkg::CH_MINUS);
               step_mode = mtd_pkg::ARG_SIGN;
            end else if (is_digit) begin
               step_value = {4'h0, digit_val};
               step_mode  = mtd_pkg::ARG_DIGITS;
            end else if (c == mtd_pkg::CH_TILDE && arg_ff == mtd_pkg::ARG_EMPTY) begin
               step_mode = mtd_pkg::ARG_TILDE1;
            end else begin
               step_mode = mtd_pkg::ARG_DONE;
            end
         end
         mtd_pkg::ARG_SIGN: begin
            if (is_digit) begin
               step_value = {4'h0, digit_val};
               step_mode  = mtd_pkg::ARG_DIGITS;
            end else begin
               step_mode = mtd_pkg::ARG_DONE;
            end
         end
         mtd_pkg::ARG_DIGITS: begin
            if (is_digit) begin
               step_value = (acc > 12'd255) ? 8'hFF : acc[7:0];
            end else begin
               step_mode = mtd_pkg::ARG_DONE;
            end
         end
         mtd_pkg::ARG_TILDE1: begin
            step_char = c;
            step_mode = mtd_pkg::ARG_TILDE2;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      tok_in       = tok_ff;
      arg_in       = arg_ff;
      arg_char_in  = arg_char_ff;
      arg_value_in = arg_value_ff;
      arg_neg_in   = arg_neg_ff;
      emit         = '0;
      case (mode_ff)
         mtd_pkg::MODE_NORMAL, mtd_pkg::MODE_CLOSE: begin
            mode_in = mtd_pkg::MODE_NORMAL;
            if (mode_ff == mtd_pkg::MODE_CLOSE && c == mtd_pkg::CH_RBRACKET) begin
               emit.data = c;
               emit.cnt  = 2'd1;
            end else if (c == mtd_pkg::CH_RBRACKET) begin
               if (!req_tlast) begin
                  mode_in = mtd_pkg::MODE_CLOSE;
               end
            end else if (c == mtd_pkg::CH_LBRACKET) begin
               if (!req_tlast) begin
                  mode_in = mtd_pkg::MODE_OPEN;
               end
            end else begin
               emit.data = c;
               emit.cnt  = 2'd1;
            end
         end
         mtd_pkg::MODE_OPEN: begin
            mode_in = mtd_pkg::MODE_NORMAL;
            if (c == mtd_pkg::CH_LBRACKET || c == mtd_pkg::CH_PERIOD ||
                c == mtd_pkg::CH_COLON || c == mtd_pkg::CH_QUESTION ||
                c == mtd_pkg::CH_SPACE || c == mtd_pkg::CH_BANG) begin
               emit.data = c;
               emit.cnt  = 2'd1;
            end else if (c != mtd_pkg::CH_RBRACKET) begin
               tok_in  = tok_first(c);
               mode_in = mtd_pkg::MODE_TOKEN;
               if (req_tlast) begin
                  emit = act_token(tok_first(c));
               end
            end
         end
         mtd_pkg::MODE_TOKEN: begin
            if (c == mtd_pkg::CH_RBRACKET) begin
               emit    = act_token(tok_ff);
               mode_in = mtd_pkg::MODE_NORMAL;
            end else if (c == mtd_pkg::CH_COLON) begin
               if (tok_ff == mtd_pkg::TOK_CHAR) begin
                  arg_in       = mtd_pkg::ARG_EMPTY;
                  arg_char_in  = 8'h00;
                  arg_value_in = 8'h00;
                  arg_neg_in   = 1'b0;
                  mode_in      = mtd_pkg::MODE_ARG;
               end else begin
                  emit    = act_token(tok_ff);
                  mode_in = mtd_pkg::MODE_SKIP;
               end
            end else begin
               tok_in = tok_step;
               if (req_tlast) begin
                  emit = act_token(tok_step);
               end
            end
         end
         mtd_pkg::MODE_ARG: begin
            if (c == mtd_pkg::CH_RBRACKET || c == mtd_pkg::CH_COLON) begin
               emit    = finish_arg(arg_ff, arg_char_ff, arg_value_ff, arg_neg_ff);
               mode_in = (c == mtd_pkg::CH_COLON) ? mtd_pkg::MODE_SKIP : mtd_pkg::MODE_NORMAL;
            end else begin
               arg_in       = step_mode;
               arg_char_in  = step_char;
               arg_value_in = step_value;
               arg_neg_in   = step_neg;
               if (req_tlast) begin
                  emit = finish_arg(step_mode, step_char, step_value, step_neg);
               end
            end
         end
         mtd_pkg::MODE_SKIP: begin
            if (c == mtd_pkg::CH_RBRACKET) begin
               mode_in = mtd_pkg::MODE_NORMAL;
            end
         end
         default: begin
            mode_in = mtd_pkg::MODE_NORMAL;
         end
      endcase
      if (req_tlast) begin
         mode_in      = mtd_pkg::MODE_NORMAL;
         tok_in       = mtd_pkg::TOK_NONE;
         arg_in       = mtd_pkg::ARG_EMPTY;
         arg_char_in  = 8'h00;
         arg_value_in = 8'h00;
         arg_neg_in   = 1'b0;
      end
   end

   assign q_push       = accept && ((emit.cnt != 2'd0) || req_tlast);
   assign q_data.data  = emit.data;
   assign q_data.valid = (emit.cnt != 2'd0);
   assign q_data.twice = (emit.cnt == 2'd2);
   assign q_data.eot   = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mtd_pkg::MODE_NORMAL;
         tok_ff       <= mtd_pkg::TOK_NONE;
         arg_ff       <= mtd_pkg::ARG_EMPTY;
         arg_char_ff  <= 8'h00;
         arg_value_ff <= 8'h00;
         arg_neg_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         tok_ff       <= tok_in;
         arg_ff       <= arg_in;
         arg_char_ff  <= arg_char_in;
         arg_value_ff <= arg_value_in;
         arg_neg_ff   <= arg_neg_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> mode_ff == mtd_pkg::MODE_NORMAL && tok_ff == mtd_pkg::TOK_NONE)
      else $error("state not cleared after end of text");
   a_last_pushes: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |-> q_push)
      else $error("end of text produced no queue entry");
`endif

endmodule

[rtl/mtd_queue.sv]
// ----------------------------------------------------------------------------
// mtd_queue
// small register queue between parser and output stage
// ----------------------------------------------------------------------------
module mtd_queue #(
   parameter int Depth = mtd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mtd_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output mtd_pkg::entry_type  head_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   mtd_pkg::entry_type     mem_ff [Depth];
   logic [PtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic                   do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   assign wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || do_pop)
      else $error("push into full queue");
`endif

endmodule

[rtl/mtd_back.sv]
// ----------------------------------------------------------------------------
// mtd_back
// output stage: expands queued entries into single result transactions
// ----------------------------------------------------------------------------
module mtd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  mtd_pkg::entry_type  q_data,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff;
   logic       rsp_user_ff;
   logic       rsp_last_ff;
   logic       half_ff, half_in;
   logic       load;
   logic       final_copy;

   assign load       = q_valid && (!rsp_valid_ff || rsp_tready);
   assign final_copy = !q_data.twice || half_ff;
   assign q_pop      = load && final_copy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      half_in      = half_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         half_in      = !final_copy;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= q_data.data;
         rsp_user_ff <= q_data.valid;
         rsp_last_ff <= q_data.eot && final_copy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_half_head: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> q_valid && q_data.twice)
      else $error("second copy pending without a doubled entry");
   a_first_copy: assert property (@(posedge clock) disable iff (reset)
      $rose(half_ff) |-> rsp_valid_ff && !rsp_last_ff)
      else $error("first copy of a doubled entry marked last");
`endif

endmodule

[rtl/markup_text_decoder.sv]
// ----------------------------------------------------------------------------
// markup_text_decoder
// streaming decoder from bracket markup to plain text bytes
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one markup byte per transaction, tlast on the final byte of
//   a string. rsp_ carries decoded bytes; tuser is 1 when tdata holds a
//   character, tlast marks the final result of the string. a string whose
//   final byte decodes to nothing still gets one result with tuser 0.
//   throughput: one input byte per cycle while the queue is not full;
//   a [B] token yields two results, sent in turn by the single output
//   register. each result is written into the queue when its byte is
//   accepted and then loaded into the output register, which drives
//   rsp_tvalid; that load waits while the output register is held.
//   the parser and the output stage are parted by a QueueDepth entry queue;
//   when the receiver stalls the queue fills and req_tready drops once it
//   is full. reset returns the parser to plain text mode and empties the
//   queue and the output register.
// ----------------------------------------------------------------------------
module markup_text_decoder #(
   parameter int QueueDepth = mtd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tuser,   // byte_valid
   output logic       rsp_tlast
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   mtd_pkg::entry_type q_wdata;
   mtd_pkg::entry_type q_rdata;

   mtd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   mtd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wdata),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_rdata)
   );

   mtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
